// ===== hdl/kbdp_pkg.sv =====
// ----------------------------------------------------------------------------
// kbdp_pkg
// Shared types, register offsets, keyboard command codes and ID table for the
// keyboard port register block.
// ----------------------------------------------------------------------------
package kbdp_pkg;

   localparam int RX_FIFO_DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_INJECT = 2'd2;

   // register offsets
   localparam logic [11:0] REG_CTRL   = 12'h000;
   localparam logic [11:0] REG_STATUS = 12'h004;
   localparam logic [11:0] REG_DATA   = 12'h008;
   localparam logic [11:0] REG_CLKDIV = 12'h00C;
   localparam logic [11:0] REG_IRQ    = 12'h010;
   localparam logic [6:0]  ID_WINDOW  = 7'h7F;   // offset bits 11:5 of 0xFE0..0xFFC

   // control register bits
   localparam int CR_EN_BIT   = 2;
   localparam int CR_TXIE_BIT = 3;
   localparam int CR_RXIE_BIT = 4;

   localparam logic [7:0] STATUS_BASE  = 8'h43;
   localparam logic [7:0] STATUS_RXNE  = 8'h10;
   localparam logic [7:0] CLKDIV_MASK  = 8'h0F;

   // keyboard commands and replies
   localparam logic [7:0] CMD_LEDS      = 8'hED;
   localparam logic [7:0] CMD_ECHO      = 8'hEE;
   localparam logic [7:0] CMD_SCANSET   = 8'hF0;
   localparam logic [7:0] CMD_ID        = 8'hF2;
   localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
   localparam logic [7:0] CMD_ENABLE    = 8'hF4;
   localparam logic [7:0] CMD_DISABLE   = 8'hF5;
   localparam logic [7:0] CMD_DEFAULTS  = 8'hF6;
   localparam logic [7:0] CMD_ALLKEYS_A = 8'hE8;
   localparam logic [7:0] CMD_ALLKEYS_B = 8'hEA;
   localparam logic [7:0] CMD_RESEND    = 8'hFE;
   localparam logic [7:0] CMD_RESET     = 8'hFF;

   localparam logic [7:0] RPL_ACK      = 8'hFA;
   localparam logic [7:0] RPL_BAT_OK   = 8'hAA;
   localparam logic [7:0] RPL_ECHO     = 8'hEE;
   localparam logic [7:0] RPL_ID0      = 8'hAB;
   localparam logic [7:0] RPL_ID1      = 8'h83;
   localparam logic [7:0] RPL_RESEND   = 8'hFE;

   localparam logic [1:0] SCANSET_DEFAULT = 2'd2;

   typedef enum logic [2:0] {
      ARG_NONE      = 3'd0,
      ARG_LEDS      = 3'd1,
      ARG_SCANSET   = 3'd2,
      ARG_TYPEMATIC = 3'd3,
      ARG_ALLKEYS   = 3'd4
   } arg_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] reg_offset;
      logic [3:0]  access_bytes;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_level;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } push_type;

   function automatic logic [7:0] id_byte(input logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         3'd0:    v = 8'h50;
         3'd1:    v = 8'h10;
         3'd2:    v = 8'h04;
         3'd3:    v = 8'h00;
         3'd4:    v = 8'h0D;
         3'd5:    v = 8'hF0;
         3'd6:    v = 8'h05;
         default: v = 8'hB1;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/ps2_keyboard_port_with_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// ps2_keyboard_port_with_rx_fifo
// Keyboard port register block with receive FIFO and command responder.
// ----------------------------------------------------------------------------
// Each beat on req_ is a bus read, a bus write or a scan byte injected from
// the keyboard side; each produces exactly one rsp_ beat with the read value
// and the receive interrupt level after the access. A data-register write
// whose reply is two or three bytes (keyboard reset, read ID, scan-set query)
// holds the work stage until its last reply byte is pushed: reply bytes enter
// the FIFO through its single write port one per cycle, unless rsp_ stalls.
// The FIFO holds RX_FIFO_DEPTH bytes and needs no clearing pass after reset.
module ps2_keyboard_port_with_rx_fifo
   import kbdp_pkg::*;
#(
   parameter int RX_FIFO_DEPTH = RX_FIFO_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type    item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic [3:0] clkdiv_ff, clkdiv_in;

   logic       advance, first, step_done, req_fire;
   logic       size_ok, is_read, is_write, is_inject;
   logic       host_valid, inject_push, pop, flush;
   logic       fifo_empty, fifo_not_empty_next, irq_now;
   logic [7:0] fifo_head;
   logic [7:0] rd_value;
   push_type   rsp_push, fifo_push;
   logic       rsp_busy, rsp_more, scan_enabled;

   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign first     = advance && !rsp_busy;
   assign step_done = advance && !rsp_more;
   assign req_stall = item_valid_ff && !step_done;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      case (item_ff.access_bytes) inside
         4'd1, 4'd2, 4'd4, 4'd8: size_ok = 1'b1;
         default:                size_ok = 1'b0;
      endcase
   end

   assign is_read   = (item_ff.operation == OP_READ) && size_ok;
   assign is_write  = (item_ff.operation == OP_WRITE) && size_ok;
   assign is_inject = (item_ff.operation == OP_INJECT);
   assign irq_now   = ctrl_ff[CR_EN_BIT] && ctrl_ff[CR_RXIE_BIT] && !fifo_empty;

   // side effects of the first work cycle
   assign host_valid  = first && is_write && (item_ff.reg_offset == REG_DATA)
                        && ctrl_ff[CR_EN_BIT];
   assign inject_push = first && is_inject && scan_enabled && ctrl_ff[CR_EN_BIT];
   assign pop         = first && is_read && (item_ff.reg_offset == REG_DATA);
   assign flush       = first && is_write && (item_ff.reg_offset == REG_CTRL)
                        && !item_ff.data_byte[CR_EN_BIT];

   always_comb begin
      fifo_push = rsp_push;
      if (inject_push) begin
         fifo_push.valid = 1'b1;
         fifo_push.data  = item_ff.data_byte;
      end
   end

   always_comb begin
      ctrl_in   = ctrl_ff;
      clkdiv_in = clkdiv_ff;
      if (first && is_write) begin
         if (item_ff.reg_offset == REG_CTRL) begin
            ctrl_in = item_ff.data_byte;
         end
         if (item_ff.reg_offset == REG_CLKDIV) begin
            clkdiv_in = item_ff.data_byte[3:0] & CLKDIV_MASK[3:0];
         end
      end
   end

   always_comb begin
      rd_value = 8'd0;
      case (item_ff.reg_offset)
         REG_CTRL:   rd_value = ctrl_ff;
         REG_STATUS: rd_value = STATUS_BASE | (fifo_empty ? 8'd0 : STATUS_RXNE);
         REG_DATA:   rd_value = fifo_empty ? 8'd0 : fifo_head;
         REG_CLKDIV: rd_value = {4'd0, clkdiv_ff};
         REG_IRQ:    rd_value = {6'd0, ctrl_ff[CR_TXIE_BIT], irq_now};
         default: begin
            if ((item_ff.reg_offset[11:5] == ID_WINDOW) &&
                (item_ff.reg_offset[1:0] == 2'd0)) begin
               rd_value = id_byte(item_ff.reg_offset[4:2]);
            end
         end
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (step_done) begin
         item_valid_in = 1'b0;
      end
      if (req_fire) begin
         item_in       = req_data;
         item_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (step_done) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.read_data = is_read ? rd_value : 8'd0;
         rsp_data_in.irq_level = ctrl_in[CR_EN_BIT] && ctrl_in[CR_RXIE_BIT]
                                 && fifo_not_empty_next;
      end
   end

   kbdp_responder u_responder (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .host_valid   (host_valid),
      .host_byte    (item_ff.data_byte),
      .push         (rsp_push),
      .busy         (rsp_busy),
      .more         (rsp_more),
      .scan_enabled (scan_enabled)
   );

   kbdp_rx_fifo #(
      .DEPTH (RX_FIFO_DEPTH)
   ) u_rx_fifo (
      .clock          (clock),
      .reset          (reset),
      .push           (fifo_push),
      .pop            (pop),
      .flush          (flush),
      .empty          (fifo_empty),
      .not_empty_next (fifo_not_empty_next),
      .head_data      (fifo_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ctrl_ff       <= 8'd0;
         clkdiv_ff     <= 4'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctrl_ff       <= ctrl_in;
         clkdiv_ff     <= clkdiv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/kbdp_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// kbdp_rx_fifo
// Receive FIFO: one write port, head byte read ahead into a register so a
// pop returns its data in the cycle it is taken. Full drops the new byte.
// ----------------------------------------------------------------------------
module kbdp_rx_fifo
   import kbdp_pkg::*;
#(
   parameter int DEPTH = RX_FIFO_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   input  logic       flush,
   output logic       empty,
   output logic       not_empty_next,
   output logic [7:0] head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W:0]   DEPTH_C = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

   logic [7:0]       mem [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic [7:0]       head_data_ff;
   logic [PTR_W:0]   tail_sum;
   logic [PTR_W-1:0] tail;
   logic             wr_en;

   always_comb begin
      tail_sum = {1'b0, head_ff} + count_ff;
      if (tail_sum >= DEPTH_C) begin
         tail_sum = tail_sum - DEPTH_C;
      end
      tail  = tail_sum[PTR_W-1:0];
      wr_en = push.valid && (count_ff != DEPTH_C);

      head_in  = head_ff;
      count_in = count_ff;
      if (flush) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (wr_en) begin
            count_in = count_in + 1'b1;
         end
         if (pop && (count_ff != '0)) begin
            count_in = count_in - 1'b1;
            head_in  = (head_ff == LAST_C) ? '0 : head_ff + 1'b1;
         end
      end
   end

   // read ahead at the next head; forward a byte landing there this cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail] <= push.data;
      end
      if (wr_en && (tail == head_in)) begin
         head_data_ff <= push.data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign empty          = (count_ff == '0);
   assign not_empty_next = (count_in != '0);
   assign head_data      = head_data_ff;

endmodule

// ===== hdl/kbdp_responder.sv =====
// ----------------------------------------------------------------------------
// kbdp_responder
// Keyboard command responder: decodes host bytes, keeps scan set, scan enable
// and pending-argument state, and issues reply bytes one per advance cycle.
// ----------------------------------------------------------------------------
module kbdp_responder
   import kbdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       host_valid,
   input  logic [7:0] host_byte,
   output push_type   push,
   output logic       busy,
   output logic       more,
   output logic       scan_enabled
);

   arg_type    await_ff, await_in;
   logic [1:0] scan_set_ff, scan_set_in;
   logic       scan_en_ff, scan_en_in;
   logic [1:0] tail_cnt_ff, tail_cnt_in;
   logic [7:0] tail0_ff, tail0_in;
   logic [7:0] tail1_ff, tail1_in;

   logic [1:0] r_cnt;
   logic [7:0] r0, r1, r2;

   always_comb begin
      await_in    = await_ff;
      scan_set_in = scan_set_ff;
      scan_en_in  = scan_en_ff;
      tail_cnt_in = tail_cnt_ff;
      tail0_in    = tail0_ff;
      tail1_in    = tail1_ff;
      push        = '0;
      r_cnt       = 2'd1;
      r0          = RPL_ACK;
      r1          = RPL_ACK;
      r2          = RPL_ACK;

      if (tail_cnt_ff != 2'd0) begin
         if (advance) begin
            push.valid  = 1'b1;
            push.data   = tail0_ff;
            tail0_in    = tail1_ff;
            tail_cnt_in = tail_cnt_ff - 2'd1;
         end
      end else if (host_valid) begin
         if (await_ff != ARG_NONE) begin
            await_in = ARG_NONE;
            if (await_ff == ARG_SCANSET) begin
               if (host_byte == 8'd0) begin
                  r_cnt = 2'd2;
                  r1    = {6'd0, scan_set_ff};
               end else if (host_byte <= 8'd3) begin
                  scan_set_in = host_byte[1:0];
               end
            end
         end else begin
            case (host_byte)
               CMD_LEDS:      await_in = ARG_LEDS;
               CMD_ECHO:      r0 = RPL_ECHO;
               CMD_SCANSET:   await_in = ARG_SCANSET;
               CMD_ID: begin
                  r_cnt = 2'd3;
                  r1    = RPL_ID0;
                  r2    = RPL_ID1;
               end
               CMD_TYPEMATIC: await_in = ARG_TYPEMATIC;
               CMD_ENABLE:    scan_en_in = 1'b1;
               CMD_DISABLE: begin
                  scan_set_in = SCANSET_DEFAULT;
                  scan_en_in  = 1'b0;
                  await_in    = ARG_NONE;
               end
               CMD_DEFAULTS: begin
                  scan_set_in = SCANSET_DEFAULT;
                  scan_en_in  = 1'b1;
                  await_in    = ARG_NONE;
               end
               CMD_ALLKEYS_A, CMD_ALLKEYS_B: await_in = ARG_ALLKEYS;
               // the last host byte is this command, so resend echoes it
               CMD_RESEND:    r0 = RPL_RESEND;
               CMD_RESET: begin
                  scan_set_in = SCANSET_DEFAULT;
                  scan_en_in  = 1'b1;
                  await_in    = ARG_NONE;
                  r_cnt       = 2'd2;
                  r1          = RPL_BAT_OK;
               end
               default: ;
            endcase
         end
         push.valid  = 1'b1;
         push.data   = r0;
         tail_cnt_in = r_cnt - 2'd1;
         tail0_in    = r1;
         tail1_in    = r2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff    <= ARG_NONE;
         scan_set_ff <= SCANSET_DEFAULT;
         scan_en_ff  <= 1'b1;
         tail_cnt_ff <= 2'd0;
      end else begin
         await_ff    <= await_in;
         scan_set_ff <= scan_set_in;
         scan_en_ff  <= scan_en_in;
         tail_cnt_ff <= tail_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tail0_ff <= tail0_in;
      tail1_ff <= tail1_in;
   end

   assign busy         = (tail_cnt_ff != 2'd0);
   assign more         = (tail_cnt_in != 2'd0);
   assign scan_enabled = scan_en_ff;

endmodule

// ===== tb/ps2_keyboard_port_with_rx_fifo_test.sv =====
// ----------------------------------------------------------------------------
// Keyboard port register block testbench
// Drives bus reads, bus writes and keyboard-side byte injects through the
// request channel. Every accepted beat runs through a cycle-free model of the
// register map, the receive FIFO and the keyboard command responder. The
// model's read value and interrupt level are then matched in order against
// the response channel. A directed opening covers the register map, the ID
// window, bad access sizes, every keyboard command but CMD_ALLKEYS_A and a
// full FIFO. Random command sequences, inject bursts, drains and noise
// follow, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module ps2_keyboard_port_with_rx_fifo_test;
   import kbdp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RX_DEPTH      = RX_FIFO_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 500;
   localparam int STALL_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 8;
   localparam logic [11:0] ID_FIRST = 12'hFE0;
   localparam logic [11:0] ID_LAST  = 12'hFFC;
   localparam logic [11:0] REG_UNUSED = 12'h100;
   localparam logic [1:0]  OP_NONE  = 2'd3;
   localparam logic [7:0]  PERIPH_ID [8] = '{8'h50, 8'h10, 8'h04, 8'h00,
                                             8'h0D, 8'hF0, 8'h05, 8'hB1};
   localparam logic [7:0]  KBD_COMMANDS [12] = '{CMD_LEDS, CMD_ECHO, CMD_SCANSET,
      CMD_ID, CMD_TYPEMATIC, CMD_ENABLE, CMD_DISABLE, CMD_DEFAULTS, CMD_ALLKEYS_A,
      CMD_ALLKEYS_B, CMD_RESEND, CMD_RESET};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ps2_keyboard_port_with_rx_fifo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // model state
   logic [7:0] m_fifo [RX_DEPTH];
   int         m_count = 0;
   int         m_head = 0;
   logic [7:0] m_ctrl = '0;
   logic [7:0] m_clkdiv = '0;
   logic [7:0] m_last_host = '0;
   logic [1:0] m_scanset = SCANSET_DEFAULT;
   logic       m_scan_en = 1'b1;
   arg_type    m_arg = ARG_NONE;

   req_type pending_accesses [$];
   rsp_type access_results [$];
   int      n_total = 0;
   int      n_counted = 0;
   int      n_req_accepted = 0;
   int      n_rsp_checked = 0;
   int      n_reads = 0;
   int      n_writes = 0;
   int      n_injects = 0;
   int      n_full_drops = 0;
   int      quiet_from = 0;
   int      req_gap = 0;
   int      rsp_hold = 0;
   bit      failed = 1'b0;
   logic    idling;

   assign idling = (n_req_accepted < quiet_from) && ((n_req_accepted % 128) < 96);

   function automatic logic rx_irq();
      return m_ctrl[CR_EN_BIT] && m_ctrl[CR_RXIE_BIT] && (m_count != 0);
   endfunction

   function automatic void rx_push(input logic [7:0] b);
      if (m_count < RX_DEPTH) begin
         m_fifo[(m_head + m_count) % RX_DEPTH] = b;
         m_count++;
      end else begin
         n_full_drops++;
      end
      if (!m_ctrl[CR_EN_BIT]) begin
         m_count = 0;
         m_head = 0;
      end
   endfunction

   function automatic void keyboard_defaults();
      m_scanset = SCANSET_DEFAULT;
      m_scan_en = 1'b1;
      m_arg = ARG_NONE;
   endfunction

   // apply one access to the model and return the response it must produce
   function automatic rsp_type port_access(input req_type r);
      rsp_type    res;
      logic       size_ok;
      logic [7:0] b;
      arg_type    arg;
      res = '0;
      b = r.data_byte;
      size_ok = (r.access_bytes == 4'd1) || (r.access_bytes == 4'd2) ||
                (r.access_bytes == 4'd4) || (r.access_bytes == 4'd8);
      case (r.operation)
         OP_READ: begin
            n_reads++;
            if (size_ok) begin
               case (r.reg_offset)
                  REG_CTRL:   res.read_data = m_ctrl;
                  REG_STATUS: res.read_data = STATUS_BASE | ((m_count != 0) ? STATUS_RXNE : 8'h00);
                  REG_DATA: begin
                     if (m_count != 0) begin
                        res.read_data = m_fifo[m_head];
                        m_head = (m_head + 1) % RX_DEPTH;
                        m_count--;
                     end
                  end
                  REG_CLKDIV: res.read_data = m_clkdiv;
                  REG_IRQ:    res.read_data = {6'd0, m_ctrl[CR_TXIE_BIT], rx_irq()};
                  default: begin
                     if (r.reg_offset >= ID_FIRST && r.reg_offset <= ID_LAST &&
                         r.reg_offset[1:0] == 2'b00)
                        res.read_data = PERIPH_ID[r.reg_offset[4:2]];
                  end
               endcase
            end
         end
         OP_WRITE: begin
            n_writes++;
            if (size_ok) begin
               case (r.reg_offset)
                  REG_CTRL: begin
                     m_ctrl = b;
                     if (!m_ctrl[CR_EN_BIT]) begin
                        m_count = 0;
                        m_head = 0;
                     end
                  end
                  REG_DATA: begin
                     m_last_host = b;
                     if (m_ctrl[CR_EN_BIT]) begin
                        if (m_arg != ARG_NONE) begin
                           // argument byte of an earlier command
                           arg = m_arg;
                           m_arg = ARG_NONE;
                           rx_push(RPL_ACK);
                           if (arg == ARG_SCANSET) begin
                              if (b == 8'd0)
                                 rx_push({6'd0, m_scanset});
                              else if (b <= 8'd3)
                                 m_scanset = b[1:0];
                           end
                        end else begin
                           case (b)
                              CMD_LEDS: begin
                                 m_arg = ARG_LEDS;
                                 rx_push(RPL_ACK);
                              end
                              CMD_ECHO: rx_push(RPL_ECHO);
                              CMD_SCANSET: begin
                                 m_arg = ARG_SCANSET;
                                 rx_push(RPL_ACK);
                              end
                              CMD_ID: begin
                                 rx_push(RPL_ACK);
                                 rx_push(RPL_ID0);
                                 rx_push(RPL_ID1);
                              end
                              CMD_TYPEMATIC: begin
                                 m_arg = ARG_TYPEMATIC;
                                 rx_push(RPL_ACK);
                              end
                              CMD_ENABLE: begin
                                 m_scan_en = 1'b1;
                                 rx_push(RPL_ACK);
                              end
                              CMD_DISABLE: begin
                                 keyboard_defaults();
                                 m_scan_en = 1'b0;
                                 rx_push(RPL_ACK);
                              end
                              CMD_DEFAULTS: begin
                                 keyboard_defaults();
                                 rx_push(RPL_ACK);
                              end
                              CMD_ALLKEYS_A, CMD_ALLKEYS_B: begin
                                 m_arg = ARG_ALLKEYS;
                                 rx_push(RPL_ACK);
                              end
                              CMD_RESEND: rx_push((m_last_host == 8'd0) ? RPL_RESEND : m_last_host);
                              CMD_RESET: begin
                                 keyboard_defaults();
                                 rx_push(RPL_ACK);
                                 rx_push(RPL_BAT_OK);
                              end
                              default: rx_push(RPL_ACK);
                           endcase
                        end
                     end
                  end
                  REG_CLKDIV: m_clkdiv = b & CLKDIV_MASK;
                  default: ;
               endcase
            end
         end
         OP_INJECT: begin
            n_injects++;
            if (m_scan_en)
               rx_push(b);
         end
         default: ;
      endcase
      res.irq_level = rx_irq();
      return res;
   endfunction

   task automatic queue_access(input logic [1:0] op, input logic [11:0] off,
                               input logic [3:0] size, input logic [7:0] b);
      req_type r;
      r.operation = op;
      r.reg_offset = off;
      r.access_bytes = size;
      r.data_byte = b;
      pending_accesses.insert(pending_accesses.size(), r);
      if (op != OP_NONE)
         n_counted++;
   endtask

   function automatic logic [3:0] legal_size();
      return 4'd1 << $urandom_range(0, 3);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_accesses.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_accesses[0];
            pending_accesses.delete(0);
            if (idling && $urandom_range(0, 7) == 0)
               req_gap <= $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check responses first, then predict the newly accepted beat
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_rsp_checked++;
            if (access_results.size() == 0) begin
               $error("response beat with nothing expected: read_data %h irq_level %b",
                      rsp_data.read_data, rsp_data.irq_level);
               failed = 1'b1;
            end else begin
               want = access_results[0];
               access_results.delete(0);
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data expected %h actual %h", want.read_data, rsp_data.read_data);
                  failed = 1'b1;
               end
               if (rsp_data.irq_level !== want.irq_level) begin
                  $error("irq_level expected %b actual %b", want.irq_level, rsp_data.irq_level);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            access_results.insert(access_results.size(), port_access(req_data));
            n_req_accepted <= n_req_accepted + 1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int         kind;
      int         reps;
      logic [7:0] cmd;
      logic [7:0] b;

      // register map and access sizes out of reset
      queue_access(OP_READ, REG_CTRL, 4'd4, 8'h00);
      queue_access(OP_READ, REG_STATUS, 4'd4, 8'h00);
      queue_access(OP_READ, REG_DATA, 4'd1, 8'h00);
      queue_access(OP_READ, ID_FIRST, 4'd4, 8'h00);
      queue_access(OP_READ, ID_LAST, 4'd8, 8'h00);
      queue_access(OP_READ, ID_FIRST + 12'd2, 4'd4, 8'h00);
      queue_access(OP_READ, REG_CTRL, 4'd0, 8'h00);
      queue_access(OP_WRITE, REG_CTRL, 4'd3, 8'hFF);
      queue_access(OP_INJECT, REG_DATA, 4'd4, 8'h5A);
      queue_access(OP_WRITE, REG_CTRL, 4'd8, 8'hFF);
      queue_access(OP_WRITE, REG_CLKDIV, 4'd2, 8'hFF);
      queue_access(OP_READ, REG_CLKDIV, 4'd4, 8'h00);
      queue_access(OP_INJECT, 12'hFFF, 4'hF, 8'h00);
      queue_access(OP_INJECT, 12'h000, 4'd0, 8'hFF);
      queue_access(OP_READ, REG_IRQ, 4'd4, 8'h00);
      // every command but CMD_ALLKEYS_A, overrunning the FIFO on the way
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_ID);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_RESET);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_RESEND);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_LEDS);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h07);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_SCANSET);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h00);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_SCANSET);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h03);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_SCANSET);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h80);
      repeat (4) queue_access(OP_READ, REG_DATA, 4'd1, 8'h00);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_TYPEMATIC);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h20);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_ALLKEYS_B);
      queue_access(OP_WRITE, REG_DATA, 4'd1, 8'h11);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_DISABLE);
      queue_access(OP_INJECT, REG_DATA, 4'd1, 8'h33);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_ENABLE);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_DEFAULTS);
      queue_access(OP_WRITE, REG_DATA, 4'd1, CMD_ECHO);
      queue_access(OP_NONE, REG_CTRL, 4'd4, 8'h00);
      queue_access(OP_WRITE, REG_UNUSED, 4'd4, 8'hA5);
      queue_access(OP_WRITE, REG_CTRL, 4'd4, 8'h00);
      queue_access(OP_READ, REG_STATUS, 4'd4, 8'h00);
      queue_access(OP_WRITE, REG_CTRL, 4'd4, 8'h1C);

      n_counted = 0;
      while (n_counted < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            // command, usually its argument where one is taken, then up to four pops
            if ($urandom_range(0, 3) == 0)
               cmd = 8'($urandom_range(0, 255));
            else
               cmd = KBD_COMMANDS[$urandom_range(0, 11)];
            queue_access(OP_WRITE, REG_DATA, legal_size(), cmd);
            if ((cmd == CMD_LEDS || cmd == CMD_SCANSET || cmd == CMD_TYPEMATIC ||
                 cmd == CMD_ALLKEYS_A || cmd == CMD_ALLKEYS_B) &&
                $urandom_range(0, 6) != 0) begin
               if (cmd == CMD_SCANSET && $urandom_range(0, 2) != 0)
                  b = 8'($urandom_range(0, 4));
               else
                  b = 8'($urandom_range(0, 255));
               queue_access(OP_WRITE, REG_DATA, legal_size(), b);
            end
            reps = $urandom_range(0, 4);
            repeat (reps)
               queue_access(OP_READ, REG_DATA, legal_size(), 8'($urandom_range(0, 255)));
         end else if (kind < 45) begin
            reps = $urandom_range(1, 20);
            repeat (reps)
               queue_access(OP_INJECT, 12'($urandom_range(0, 4095)),
                            4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end else if (kind < 62) begin
            reps = $urandom_range(1, 8);
            repeat (reps) queue_access(OP_READ, REG_DATA, legal_size(), 8'h00);
         end else if (kind < 70) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0)
               b[CR_EN_BIT] = 1'b1;
            if ($urandom_range(0, 1) != 0)
               queue_access(OP_WRITE, REG_CTRL, legal_size(), b);
            else
               queue_access(OP_WRITE, REG_CLKDIV, legal_size(), b);
         end else if (kind < 80) begin
            case ($urandom_range(0, 5))
               0: queue_access(OP_READ, REG_CTRL, legal_size(), 8'h00);
               1: queue_access(OP_READ, REG_STATUS, legal_size(), 8'h00);
               2: queue_access(OP_READ, REG_CLKDIV, legal_size(), 8'h00);
               3: queue_access(OP_READ, REG_IRQ, legal_size(), 8'h00);
               default: queue_access(OP_READ, ID_FIRST + 12'($urandom_range(0, 31)),
                                     legal_size(), 8'h00);
            endcase
         end else begin
            queue_access(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end
      end

      n_total = pending_accesses.size();
      quiet_from = n_total - n_total / 8;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (n_req_accepted < n_total);
      do @(negedge clock); while (access_results.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d accesses checked: %0d reads, %0d writes, %0d keyboard injects",
               n_rsp_checked, n_reads, n_writes, n_injects);
      $display("receive FIFO overran %0d times; %0d beats still expected",
               n_full_drops, access_results.size());
      if (failed)
         $display("Test completed with failures");
      else
         $display("Test completed successfully");
      $finish;
   end

endmodule

// ===== ps2_keyboard_port_with_rx_fifo.f =====
hdl/kbdp_pkg.sv
hdl/kbdp_rx_fifo.sv
hdl/kbdp_responder.sv
hdl/ps2_keyboard_port_with_rx_fifo.sv
tb/ps2_keyboard_port_with_rx_fifo_test.sv
